[rtl/lru_key_value_cache_macros.svh]
// Assertion macros shared by the checker of lru_key_value_cache.
// Depends on nothing; expects clk and rst_n in the scope that uses them.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Implication checked out of reset.
`define LKVC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru cache port check failed");

// Next-cycle implication that stays live during reset.
`define LKVC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lru cache port check failed");

`endif

[rtl/lkvc_pkg.sv]
// Types and constants of the LRU key-value cache.
// Used by lru_key_value_cache, lkvc_checker and tb_top; no dependencies.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [DATA_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0]  store_value;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [DATA_W-1:0]  read_value;
  } rsp_t;

  // Clamp the capacity register to 1..ENTRIES.
  function automatic logic [CNT_W-1:0] cap_clamp(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] c;
    logic [CNT_W-1:0] res;
    c = CMP_W'(cap);
    if (c == '0) begin
      res = CNT_W'(1);
    end else if (c > CMP_W'(ENTRIES)) begin
      res = CNT_W'(ENTRIES);
    end else begin
      res = CNT_W'(c);
    end
    return res;
  endfunction

endpackage

[rtl/lru_key_value_cache.sv]
// LRU key-value cache: fully associative, ENTRIES slots, least recent evicted.
// A get is captured in the request register when accepted; its result beat is then registered in the result register.
// Throughput: one request per cycle while busy is low; each beat is resolved in a single pass
// from the request register to the result register. Results cannot be stalled.
// Reset (rst_n low, synchronous): cache empty, capacity 16, busy for one cycle.
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  req_t             in_req,
  output logic             out_valid,
  output rsp_t             out_rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic                     busy_r;
  logic                     in_vld_r;
  req_t                     in_r;
  logic [CAP_W-1:0]         cap_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [ENTRIES-1:0]       valid_r;
  logic [ENTRIES-1:0]       valid_nxt;
  logic [IDX_W-1:0]         rank_r   [ENTRIES];
  logic [IDX_W-1:0]         rank_nxt [ENTRIES];
  logic [DATA_W-1:0]        keys_r   [ENTRIES];
  logic [DATA_W-1:0]        vals_r   [ENTRIES];
  logic                     out_valid_r;
  rsp_t                     rsp_r;

  logic [ENTRIES-1:0]       match;
  logic [ENTRIES-1:0]       victim;
  logic [ENTRIES-1:0]       after_evict;
  logic [ENTRIES-1:0]       free_slots;
  logic [ENTRIES-1:0]       ins_oh;
  logic [ENTRIES-1:0]       wr_val;
  logic [IDX_W-1:0]         prom     [ENTRIES];
  logic                     hit;
  logic [DATA_W-1:0]        hit_val;
  logic [IDX_W-1:0]         hit_rank;
  logic [IDX_W-1:0]         oldest;
  logic [CNT_W-1:0]         cap_eff;
  logic                     is_put;
  logic                     upd_evict;
  logic                     ins_evict;
  logic                     do_insert;

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (keys_r[i] == in_r.lookup_key);
      if (match[i]) begin
        hit_val  = hit_val | vals_r[i];
        hit_rank = hit_rank | rank_r[i];
      end
    end
    hit = |match;
  end

  // Ranks of live entries are a permutation of 0..count-1, so the least
  // recent entry is the one holding rank count-1.
  always_comb begin
    cap_eff   = cap_clamp(cap_r);
    oldest    = IDX_W'(count_r - CNT_W'(1));
    is_put    = in_vld_r && (in_r.opcode == OP_PUT);
    upd_evict = is_put && hit && (count_r > cap_eff);
    ins_evict = is_put && !hit && (count_r >= cap_eff);
    do_insert = is_put && !hit;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        prom[i] = '0;
      end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
        prom[i] = rank_r[i] + IDX_W'(1);
      end else begin
        prom[i] = rank_r[i];
      end
      victim[i] = valid_r[i] &&
                  ((upd_evict && (prom[i] == oldest)) ||
                   (ins_evict && (rank_r[i] == oldest)));
    end
    after_evict = valid_r & ~victim;
    free_slots  = ~after_evict;
    ins_oh      = do_insert ? (free_slots & (~free_slots + ENTRIES'(1))) : '0;
    wr_val      = ins_oh | ((is_put && hit) ? match : '0);
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (in_vld_r) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          rank_nxt[i] = prom[i];
        end
        valid_nxt = after_evict;
        count_nxt = count_r - {{(CNT_W-1){1'b0}}, upd_evict};
      end else if (do_insert) begin
        for (int i = 0; i < ENTRIES; i++) begin
          rank_nxt[i] = ins_oh[i] ? '0 : (rank_r[i] + IDX_W'(1));
        end
        valid_nxt = after_evict | ins_oh;
        count_nxt = count_r - {{(CNT_W-1){1'b0}}, ins_evict} + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      in_vld_r    <= 1'b0;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      busy_r      <= 1'b0;
      in_vld_r    <= start && !busy_r;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= in_vld_r && (in_r.opcode == OP_GET);
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_r <= in_req;
    end
    rsp_r.hit        <= hit;
    rsp_r.read_value <= hit ? hit_val : MISS_VALUE;
    for (int i = 0; i < ENTRIES; i++) begin
      if (in_vld_r && ins_oh[i]) begin
        keys_r[i] <= in_r.lookup_key;
      end
      if (in_vld_r && wr_val[i]) begin
        vals_r[i] <= in_r.store_value;
      end
    end
  end

endmodule

[rtl/lkvc_checker.sv]
// Port-level checks for lru_key_value_cache, bound into each instance of it.
// Depends on lkvc_pkg and lru_key_value_cache_macros.svh.
`include "lru_key_value_cache_macros.svh"

module lkvc_checker
  import lkvc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input req_t             in_req,
  input logic             out_valid,
  input rsp_t             out_rsp
);

  logic get_beat;

  assign get_beat = start && !busy && (in_req.opcode == OP_GET);

  `LKVC_ASSERT_NXT(a_quiet_after_reset, !rst_n, !out_valid)
  `LKVC_ASSERT_IMP(a_get_gives_result, get_beat, ##2 out_valid)
  `LKVC_ASSERT_IMP(a_result_from_get, out_valid, $past(get_beat, 2))
  `LKVC_ASSERT_IMP(a_miss_value, out_valid && !out_rsp.hit, out_rsp.read_value == MISS_VALUE)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

[dv/tb_top.sv]
// Self-checking testbench for lru_key_value_cache: directed corner cases, then
// random get/put traffic over small key pools across several capacity settings.
// Depends on lkvc_pkg and lru_key_value_cache from rtl/.
module tb_top;
  import lkvc_pkg::*;

  class lru_scoreboard;
    logic [DATA_W-1:0] slot_key [ENTRIES];
    logic [DATA_W-1:0] slot_val [ENTRIES];
    logic              slot_live[ENTRIES];
    logic [IDX_W-1:0]  slot_age [ENTRIES];
    logic [CAP_W-1:0]  capacity;
    rsp_t              lookup_q[$];
    int                mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_live[i] = 1'b0;
        slot_age[i]  = '0;
      end
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int pending();
      return lookup_q.size();
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++) if (slot_live[i]) n++;
      return n;
    endfunction

    function int effective_capacity();
      int c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function void make_newest(int idx);
      logic [IDX_W-1:0] a;
      a = slot_age[idx];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_age[i] < a) slot_age[i] = slot_age[i] + 1'b1;
      slot_age[idx] = '0;
    endfunction

    function void drop_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) begin
        slot_live[victim] = 1'b0;
        slot_age[victim]  = '0;
      end
    endfunction

    // Accepted request beat: update the predicted store, queue a get's answer.
    function void note_request(req_t r);
      int   idx;
      bit   placed;
      rsp_t want;
      idx = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (idx < 0 && slot_live[i] && slot_key[i] == r.lookup_key) idx = i;
      if (r.opcode == OP_GET) begin
        if (idx >= 0) begin
          make_newest(idx);
          want.hit        = 1'b1;
          want.read_value = slot_val[idx];
        end else begin
          want.hit        = 1'b0;
          want.read_value = MISS_VALUE;
        end
        lookup_q.push_back(want);
      end else if (idx >= 0) begin
        slot_val[idx] = r.store_value;
        make_newest(idx);
        if (live_count() > effective_capacity()) drop_oldest();
      end else begin
        if (live_count() + 1 > effective_capacity()) drop_oldest();
        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!placed && !slot_live[i]) begin
            for (int j = 0; j < ENTRIES; j++)
              if (slot_live[j]) slot_age[j] = slot_age[j] + 1'b1;
            slot_live[i] = 1'b1;
            slot_key[i]  = r.lookup_key;
            slot_val[i]  = r.store_value;
            slot_age[i]  = '0;
            placed       = 1'b1;
          end
        end
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (lookup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with no get outstanding: hit %0b value %h",
                   got.hit, got.read_value);
      end else begin
        want = lookup_q.pop_front();
        if (got.hit !== want.hit || got.read_value !== want.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("get result mismatch: hit exp %0b got %0b, value exp %h got %h",
                     want.hit, got.hit, want.read_value, got.read_value);
        end
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  req_t             in_req    = '0;
  logic             out_valid;
  rsp_t             out_rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  lru_scoreboard sb;

  lru_key_value_cache uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_rsp);
      if (start && !busy) sb.note_request(in_req);
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
    end
  end

  // Called at a falling edge; returns at a falling edge with start still high.
  task automatic send_request(input opcode_t op, input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] val, input int gap);
    req_t r;
    r.opcode      = op;
    r.lookup_key  = key;
    r.store_value = val;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put(input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] val);
    send_request(OP_PUT, key, val, 0);
  endtask

  task automatic get(input logic [DATA_W-1:0] key);
    send_request(OP_GET, key, $urandom, 0);
  endtask

  // Idle the request side until every get has answered, then keep idling so that
  // a trailing put settles.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0]  phase_cap[9];
    logic [DATA_W-1:0] pool[24];
    logic [DATA_W-1:0] key;
    opcode_t           op;
    int                pool_size;
    int                pause_at;
    int                gap;
    bit                no_idle;

    sb = new();
    phase_cap = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2, 5'd17, 5'd12};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty miss, key/value extremes, update, miss on absent key
    get(32'h0000_0000);
    put(32'h8000_0000, 32'h7fff_ffff);
    put(32'h7fff_ffff, 32'h8000_0000);
    put(32'h0000_0000, 32'h0000_0000);
    put(32'hffff_ffff, 32'hffff_ffff);
    get(32'h8000_0000);
    get(32'h7fff_ffff);
    get(32'h0000_0001);
    put(32'h0000_0000, 32'h1234_5678);
    get(32'h0000_0000);
    get(32'hffff_ffff);
    // capacity lowered below the live count: one eviction per later put
    write_capacity(5'd2);
    put(32'h7fff_ffff, 32'h0000_0005);
    put(32'h0000_0007, 32'h0000_0008);
    get(32'h0000_0000);
    get(32'h8000_0000);
    get(32'h0000_0007);
    // zero capacity behaves as one
    write_capacity(5'd0);
    put(32'h0000_0009, 32'h0000_0001);
    put(32'h0000_000a, 32'h0000_0002);
    get(32'h0000_0009);
    get(32'h0000_000a);
    // capacity above the store size clamps to the store size
    write_capacity(5'd31);
    put(32'h0000_000b, 32'h0000_0003);
    get(32'h0000_000a);
    get(32'h0000_000b);

    for (int p = 0; p < 9; p++) begin
      write_capacity((p == 8) ? CAP_W'($urandom_range(1, 31)) : phase_cap[p]);
      pool_size = $urandom_range(2, 24);
      for (int k = 0; k < 24; k++) pool[k] = $urandom;
      pause_at = $urandom_range(10, 140);
      no_idle  = (p % 3 == 1);
      for (int i = 0; i < 150; i++) begin
        if (i == pause_at) drain();
        key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                           : $urandom;
        op  = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        send_request(op, key, $urandom, gap);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
dv/tb_top.sv
